/* rtl/sm4_pkg.sv */
// ---------------------------------------------------------------------------
// sm4_pkg
// shared types, constants and lookup functions for the sm4 cipher unit
// ---------------------------------------------------------------------------
`default_nettype none

package sm4_pkg;

  localparam int ROUNDS_DEFAULT = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT  = 2'd2;

  // system parameter fk
  localparam logic [31:0] FK0 = 32'hA3B1BAC6;
  localparam logic [31:0] FK1 = 32'h56AA3350;
  localparam logic [31:0] FK2 = 32'h677D9197;
  localparam logic [31:0] FK3 = 32'hB27022DC;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_EXP,
    ST_PREP,
    ST_ROUND,
    ST_FINISH
  } sm4_fsm_t;

  // four-word working state, w0 is the oldest word
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } sm4_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [7:0] sbox_lookup(input logic [7:0] idx);
    return SBOX[idx];
  endfunction

  // ck word for key round i: byte j is (4*i + j) * 7 mod 256, msb first
  function automatic logic [31:0] ck_word(input logic [5:0] i);
    logic [7:0]  base;
    logic [31:0] w;
    base = {i, 2'b00};
    w    = '0;
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
    end
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/sm4_block_cipher_ecb_unit.sv */
// ---------------------------------------------------------------------------
// sm4_block_cipher_ecb_unit
// sm4 ecb encrypt / decrypt with one shared round unit and a round key store
// ---------------------------------------------------------------------------
// usage:
//   - cfg channel writes key_high, key_low (either clears the key-ready flag)
//     and the decrypt bit; cfg_ready is always high, write only while idle
//   - s_* takes one 128-bit block per beat, m_* returns one block per beat,
//     tlast is carried from input to output
//   - the first block after a key write expands the key first, at
//     one key round per cycle through the shared round unit, keys written
//     to the round key store in forward order
//   - every block then takes a load step and 32 rounds, one per cycle,
//     through the same round unit; the key store read is registered and is
//     issued in the cycle before each round
//   - no new block is taken while one is still in the rounds;
//     s_tready is high only while the sequencer is idle
//   - the result sits in an output register; the next block is taken while
//     it waits, and a finished block waits in the core if m_tready is low
//   - reset clears the sequencer, key regs, decrypt bit and key-ready flag;
//     the key store itself is not cleared
// ---------------------------------------------------------------------------
`default_nettype none

module sm4_block_cipher_ecb_unit
  import sm4_pkg::*;
#(
  parameter int NUM_ROUNDS = ROUNDS_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst,
  // config write channel
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]     cfg_data,
  // input blocks
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [127:0]    s_tdata,   // [63:0] block_high, [127:64] block_low
  input  wire logic            s_tlast,   // last_block
  // output blocks
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [127:0]         m_tdata,   // [63:0] out_high, [127:64] out_low
  output logic                 m_tlast    // out_last
);

  localparam int AW = $clog2(NUM_ROUNDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_ROUNDS - 1);

  // config registers
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        decrypt;
  logic        keys_ready;

  // sequencer
  sm4_fsm_t    state;
  sm4_fsm_t    state_next;
  logic [AW-1:0] cnt;

  // datapath
  sm4_state_t  x;
  logic [127:0] blk;
  logic        blk_last;
  logic [31:0] new_word;
  logic [31:0] rk;
  logic [31:0] rk_rd;
  logic [AW-1:0] rd_addr;

  // control decode
  logic        in_beat;
  logic        key_wr;
  logic        cnt_last;
  logic        out_free;
  logic        key_mode;
  logic        do_shift;
  logic        load_blk;
  logic        load_out;
  logic        key_done;

  assign cfg_ready = 1'b1;
  assign in_beat   = s_tvalid && s_tready;
  assign key_wr    = cfg_valid && cfg_ready &&
                     (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);
  assign cnt_last  = (cnt == LAST_IDX);
  assign out_free  = !m_tvalid || m_tready;

  // round key index for a round, reversed for decryption
  function automatic logic [AW-1:0] key_idx(input logic [AW-1:0] i, input logic dec);
    return dec ? LAST_IDX - i : i;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = keys_ready ? ST_PREP : ST_KEY_EXP;
        end
      end
      ST_KEY_EXP: begin
        if (cnt_last) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    key_mode = 1'b0;
    do_shift = 1'b0;
    load_blk = 1'b0;
    load_out = 1'b0;
    key_done = 1'b0;
    rd_addr  = key_idx('0, decrypt);
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_KEY_EXP: begin
        key_mode = 1'b1;
        do_shift = 1'b1;
        key_done = cnt_last;
      end
      ST_PREP: begin
        load_blk = 1'b1;
      end
      ST_ROUND: begin
        do_shift = 1'b1;
        // prefetch the key for the following round
        rd_addr  = key_idx(cnt + AW'(1), decrypt);
      end
      ST_FINISH: begin
        load_out = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // shared round unit: ck in key expansion, stored round key otherwise
  assign rk = key_mode ? ck_word(6'(cnt)) : rk_rd;

  sm4_round u_round (
    .x        (x),
    .rk       (rk),
    .key_mode (key_mode),
    .new_word (new_word)
  );

  sm4_key_ram #(
    .DEPTH (NUM_ROUNDS),
    .AW    (AW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_mode),
    .wr_addr (cnt),
    .wr_data (new_word),
    .rd_addr (rd_addr),
    .rd_data (rk_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      key_high   <= '0;
      key_low    <= '0;
      decrypt    <= 1'b0;
      keys_ready <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;

      if (do_shift) begin
        cnt <= cnt + AW'(1);
      end else if (load_blk) begin
        cnt <= '0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KEY_HIGH: key_high <= cfg_data;
          CFG_KEY_LOW:  key_low  <= cfg_data;
          CFG_DECRYPT:  decrypt  <= cfg_data[0];
          default:      ;
        endcase
      end

      if (key_wr) begin
        keys_ready <= 1'b0;
      end else if (key_done) begin
        keys_ready <= 1'b1;
      end

      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      blk      <= s_tdata;
      blk_last <= s_tlast;
      // key words with fk, used only when an expansion follows
      x.w0 <= key_high[63:32] ^ FK0;
      x.w1 <= key_high[31:0]  ^ FK1;
      x.w2 <= key_low[63:32]  ^ FK2;
      x.w3 <= key_low[31:0]   ^ FK3;
    end else if (load_blk) begin
      x.w0 <= blk[63:32];
      x.w1 <= blk[31:0];
      x.w2 <= blk[127:96];
      x.w3 <= blk[95:64];
    end else if (do_shift) begin
      x <= '{w0: x.w1, w1: x.w2, w2: x.w3, w3: new_word};
    end

    // output is the final state in reverse word order
    if (load_out) begin
      m_tdata <= {x.w1, x.w0, x.w3, x.w2};
      m_tlast <= blk_last;
    end
  end

  // no block starts its rounds without a full key schedule
  a_round_keys: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP) |-> keys_ready)
    else $error("rounds started without expanded keys");

  // the last key round marks the schedule ready unless a key write lands
  a_key_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KEY_EXP && cnt_last && !key_wr) |=> keys_ready)
    else $error("key expansion did not set keys_ready");

  // a finished block reaches the output register and frees the sequencer
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished block not delivered");

  // input is taken only while no rounds are in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND || state == ST_KEY_EXP) |-> !s_tready)
    else $error("input accepted during processing");

endmodule

`default_nettype wire

/* rtl/sm4_round.sv */
// ---------------------------------------------------------------------------
// sm4_round
// one sm4 round: tau substitution then the l (data) or l' (key) transform
// ---------------------------------------------------------------------------
`default_nettype none

module sm4_round
  import sm4_pkg::*;
(
  input  wire sm4_state_t  x,
  input  wire logic [31:0] rk,
  input  wire logic        key_mode,
  output logic [31:0]      new_word
);

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] lin;

  assign a = x.w1 ^ x.w2 ^ x.w3 ^ rk;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      b[8*k +: 8] = sbox_lookup(a[8*k +: 8]);
    end
  end

  always_comb begin
    if (key_mode) begin
      lin = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    end else begin
      lin = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
              ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    end
  end

  assign new_word = x.w0 ^ lin;

endmodule

`default_nettype wire

/* rtl/sm4_key_ram.sv */
// ---------------------------------------------------------------------------
// sm4_key_ram
// round key store, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module sm4_key_ram
  import sm4_pkg::*;
#(
  parameter int DEPTH = ROUNDS_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire              clk,
  input  wire logic        wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]      rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
